FILE: rtl/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, request codes, flag bits and helpers for the sample-slot
// scheduler and header stamper.
// ----------------------------------------------------------------------------
package sss_pkg;

    // request kinds
    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_NOTIFY  = 2'd1;
    localparam logic [1:0] REQ_CONNECT = 2'd2;
    localparam logic [1:0] REQ_SEED    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SLOT_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_CATCHUP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ACCEL_CLIP    = 2'd2;
    localparam logic [1:0] CFG_GYRO_CLIP     = 2'd3;

    localparam int CFG_DATA_W = 24;

    localparam logic [19:0] SLOT_INTERVAL_RST = 20'd10000;
    localparam logic [23:0] CATCHUP_LIMIT_RST = 24'd250000;
    localparam logic [14:0] CLIP_LEVEL_RST    = 15'd32440;

    // flag bit positions
    localparam int FLAG_ACCEL_CLIP = 0;
    localparam int FLAG_GYRO_CLIP  = 1;
    localparam int FLAG_READ_FAIL  = 2;
    localparam int FLAG_LATE       = 3;
    localparam int FLAG_RESYNC     = 4;

    localparam logic [7:0] DROP_MAX = 8'd255;

    localparam logic signed [15:0] JITTER_MIN = -16'sd32768;
    localparam logic signed [15:0] JITTER_MAX = 16'sd32767;

    typedef struct packed {
        logic [19:0] slot_interval_us;
        logic [23:0] catchup_limit_us;
        logic [14:0] accel_clip_level;
        logic [14:0] gyro_clip_level;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        now_us;
        logic [31:0]        read_time_us;
        logic               read_ok;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic               notify_ok;
        logic               client_connected;
    } item_t;

    typedef struct packed {
        logic [4:0]         flags;
        logic [7:0]         dropped_count;
        logic [31:0]        slot_time_us;
        logic [31:0]        sequence_number;
        logic signed [15:0] jitter_us;
    } result_t;

    // magnitude of a raw signed sample; -32768 gives 32768
    function automatic logic [16:0] magnitude16(input logic [15:0] raw);
        logic [16:0] mag;
        begin
            if (raw[15])
                mag = 17'h10000 - {1'b0, raw};
            else
                mag = {1'b0, raw};
            return mag;
        end
    endfunction

    function automatic logic any_clip(input logic [15:0] a, input logic [15:0] b,
                                      input logic [15:0] c, input logic [14:0] level);
        logic [16:0] lv;
        begin
            lv = {2'b00, level};
            return (magnitude16(a) >= lv) || (magnitude16(b) >= lv) ||
                   (magnitude16(c) >= lv);
        end
    endfunction

endpackage

FILE: rtl/sample_slot_scheduler_stamper_top.sv
`timescale 1ns / 1ps
// Path: a due poll's item is loaded into the input register when it is accepted,
// and its result is loaded into the result register when that item advances.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset: rst_n is asynchronous, active low; clears both stages, the schedule,
// the counters and loads the register defaults.
// ----------------------------------------------------------------------------
// sample_slot_scheduler_stamper_top
// Sample-slot scheduler and packet header stamper, stream in and out.
// ----------------------------------------------------------------------------
module sample_slot_scheduler_stamper_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_us[31:0], read_time_us[63:32], read_ok[64], accel_x[80:65],
    // accel_y[96:81], accel_z[112:97], gyro_x[128:113], gyro_y[144:129],
    // gyro_z[160:145], notify_ok[161], client_connected[162], zero[167:163]
    input  logic [167:0]                   s_tdata,
    // req_type[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // dropped_count[7:0], slot_time_us[39:8], sequence_number[71:40],
    // jitter_us[87:72]
    output logic [87:0]                    m_tdata,
    // flags[4:0]
    output logic [4:0]                     m_tuser
);

    sss_pkg::cfg_t    cfg;
    sss_pkg::item_t   item_reg;
    sss_pkg::result_t res;
    sss_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             fire;
    logic             due;

    sss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sss_sched u_sched
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .fire   (fire),
        .due    (due),
        .result (res)
    );

    // advance the held item when the result register can take its stamp
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type         <= s_tuser;
            item_reg.now_us           <= s_tdata[31:0];
            item_reg.read_time_us     <= s_tdata[63:32];
            item_reg.read_ok          <= s_tdata[64];
            item_reg.accel_x          <= s_tdata[80:65];
            item_reg.accel_y          <= s_tdata[96:81];
            item_reg.accel_z          <= s_tdata[112:97];
            item_reg.gyro_x           <= s_tdata[128:113];
            item_reg.gyro_y           <= s_tdata[144:129];
            item_reg.gyro_z           <= s_tdata[160:145];
            item_reg.notify_ok        <= s_tdata[161];
            item_reg.client_connected <= s_tdata[162];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && due)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && due)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.flags;
    assign m_tdata  = {out_reg.jitter_us, out_reg.sequence_number,
                       out_reg.slot_time_us, out_reg.dropped_count};

endmodule

FILE: rtl/sss_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_cfg
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module sss_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
    output sss_pkg::cfg_t                  cfg
);

    sss_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_interval_us <= sss_pkg::SLOT_INTERVAL_RST;
            cfg_reg.catchup_limit_us <= sss_pkg::CATCHUP_LIMIT_RST;
            cfg_reg.accel_clip_level <= sss_pkg::CLIP_LEVEL_RST;
            cfg_reg.gyro_clip_level  <= sss_pkg::CLIP_LEVEL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sss_pkg::CFG_SLOT_INTERVAL: cfg_reg.slot_interval_us <= cfg_data[19:0];
                sss_pkg::CFG_CATCHUP_LIMIT: cfg_reg.catchup_limit_us <= cfg_data[23:0];
                sss_pkg::CFG_ACCEL_CLIP:    cfg_reg.accel_clip_level <= cfg_data[14:0];
                sss_pkg::CFG_GYRO_CLIP:     cfg_reg.gyro_clip_level  <= cfg_data[14:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/sss_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_sched
// Slot schedule, sequence and drop counters, and the stamp for a due poll.
// ----------------------------------------------------------------------------
module sss_sched
(
    input  logic             clk,
    input  logic             rst_n,
    input  sss_pkg::cfg_t    cfg,
    input  sss_pkg::item_t   item,
    input  logic             fire,
    output logic             due,
    output sss_pkg::result_t result
);

    logic [31:0] last_slot_reg, last_slot_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  drop_reg, drop_next;

    logic [31:0] elapsed;
    logic        is_poll;
    logic        resync;
    logic [31:0] slot;
    logic [31:0] diff;
    logic        late;
    logic        in_range;
    logic [4:0]  flags;

    always_comb
    begin
        is_poll  = (item.req_type == sss_pkg::REQ_POLL);
        elapsed  = item.now_us - last_slot_reg;
        due      = is_poll && (elapsed >= {12'd0, cfg.slot_interval_us});
        resync   = elapsed > {8'd0, cfg.catchup_limit_us};
        slot     = resync ? item.now_us : last_slot_reg + {12'd0, cfg.slot_interval_us};
        diff     = item.read_time_us - slot;
        late     = $signed(diff) >= $signed({12'd0, cfg.slot_interval_us});
        // fits in int16 when the top 17 bits all agree
        in_range = (diff[31:15] == {17{diff[15]}});

        flags = '0;
        flags[sss_pkg::FLAG_ACCEL_CLIP] = sss_pkg::any_clip(item.accel_x, item.accel_y,
                                              item.accel_z, cfg.accel_clip_level);
        flags[sss_pkg::FLAG_GYRO_CLIP]  = sss_pkg::any_clip(item.gyro_x, item.gyro_y,
                                              item.gyro_z, cfg.gyro_clip_level);
        flags[sss_pkg::FLAG_READ_FAIL]  = !item.read_ok;
        flags[sss_pkg::FLAG_LATE]       = late;
        flags[sss_pkg::FLAG_RESYNC]     = resync;

        result.flags           = flags;
        result.dropped_count   = drop_reg;
        result.slot_time_us    = slot;
        result.sequence_number = seq_reg;
        if (in_range)
            result.jitter_us = $signed(diff[15:0]);
        else if (diff[31])
            result.jitter_us = sss_pkg::JITTER_MIN;
        else
            result.jitter_us = sss_pkg::JITTER_MAX;
    end

    always_comb
    begin
        last_slot_next = last_slot_reg;
        seq_next       = seq_reg;
        drop_next      = drop_reg;
        case (item.req_type)
            sss_pkg::REQ_SEED:    last_slot_next = item.now_us;
            sss_pkg::REQ_CONNECT: drop_next = '0;
            sss_pkg::REQ_NOTIFY:
            begin
                if (item.client_connected)
                begin
                    if (item.notify_ok)
                        drop_next = '0;
                    else if (drop_reg != sss_pkg::DROP_MAX)
                        drop_next = drop_reg + 8'd1;
                end
            end
            sss_pkg::REQ_POLL:
            begin
                if (due)
                begin
                    last_slot_next = slot;
                    seq_next       = seq_reg + 32'd1;
                end
            end
            default: last_slot_next = last_slot_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_slot_reg <= '0;
            seq_reg       <= '0;
            drop_reg      <= '0;
        end
        else if (fire)
        begin
            last_slot_reg <= last_slot_next;
            seq_reg       <= seq_next;
            drop_reg      <= drop_next;
        end
    end

endmodule
